// ===== sv/ssr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the supersample resolve block.
// No dependencies; every other file of the block imports this package.
package ssr_pkg;

    // Frame geometry and block size (SCALE is a power of two)
    localparam int MAX_WIDTH  = 2048;
    localparam int SCALE_LOG2 = 2;
    localparam int SCALE      = 1 << SCALE_LOG2;

    // Sample and pixel formats
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 12;
    localparam int PIXEL_W  = 8;
    localparam logic [PIXEL_W-1:0] ALPHA_OPAQUE = '1;

    // Derived widths
    // horizontal partial per channel: a width change that wraps a line mid-block
    // leaves up to three samples behind, so it can hold seven samples
    localparam int HP_W   = SAMPLE_W + SCALE_LOG2 + 1;
    // block sum per channel: entries skipped by a narrower first line keep
    // growing, so keep full 32-bit wrap
    localparam int SUM_W  = 32;
    localparam int ACC_W  = 3 * SUM_W;                   // row accumulator word
    localparam int OCOL_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = OCOL_W + SCALE_LOG2;
    localparam int WID_W  = OCOL_W + 1;
    localparam int LEN_W  = WID_W + SCALE_LOG2;

    // Configuration port
    localparam int LW_W       = 12;
    localparam int LW_RESET   = 640;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    typedef enum logic {
        REG_ENABLE_FSAA = 1'b0,
        REG_LINE_WIDTH  = 1'b1
    } t_reg_idx;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [PIXEL_W-1:0] blue;
        logic [PIXEL_W-1:0] green;
        logic [PIXEL_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } t_queue_status;

endpackage

// ===== sv/ssr_sample_if.sv =====
`timescale 1ns / 1ps
// Input channel: one color sample word with a valid/ready handshake.
// Depends on ssr_pkg for the sample width.
interface ssr_sample_if import ssr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       start_of_frame;
    logic signed [SAMPLE_W-1:0] sample_red;
    logic signed [SAMPLE_W-1:0] sample_green;
    logic signed [SAMPLE_W-1:0] sample_blue;

    modport source (
        output valid, start_of_frame, sample_red, sample_green, sample_blue,
        input  ready
    );
    modport sink (
        input  valid, start_of_frame, sample_red, sample_green, sample_blue,
        output ready
    );
endinterface

// ===== sv/ssr_pixel_if.sv =====
`timescale 1ns / 1ps
// Output channel: one BGRA pixel word with a valid/ready handshake.
// Depends on ssr_pkg for the pixel width.
interface ssr_pixel_if import ssr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_blue;
    logic [PIXEL_W-1:0] pixel_green;
    logic [PIXEL_W-1:0] pixel_red;
    logic [PIXEL_W-1:0] pixel_alpha;

    modport source (
        output valid, pixel_blue, pixel_green, pixel_red, pixel_alpha,
        input  ready
    );
    modport sink (
        input  valid, pixel_blue, pixel_green, pixel_red, pixel_alpha,
        output ready
    );
endinterface

// ===== sv/ssr_out_queue.sv =====
`timescale 1ns / 1ps
// Small output queue that decouples the resolve pipeline from the pixel sink.
// Depends on ssr_pkg for the pixel type and queue depth.
module ssr_out_queue import ssr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_pixel        i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output t_pixel        o_data,
    output t_queue_status o_status
);

    t_pixel             r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid         = (r_count != '0);
    assign o_data          = r_entry[r_rd_ptr];
    assign o_status.count  = r_count;
    assign o_status.full   = (r_count == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== sv/supersample_resolve_4x4.sv =====
`timescale 1ns / 1ps
// Supersample resolve: turns a raster stream of signed Q3.12 RGB samples into
// BGRA bytes, either one pixel per sample or one pixel per 4x4 sample block.
// Depends on ssr_pkg, ssr_sample_if, ssr_pixel_if and ssr_out_queue.
//
// Usage: one sample is taken per clock, back to back, with no stall while the
// pixel sink keeps up. A sample moves through three steps: the accept cycle
// updates the column counters and the horizontal partial sum and reads the
// per-column row accumulator RAM; the next cycle adds the read word, writes
// it back and converts to bytes; the byte triple then waits in a four-entry
// output queue until the pixel sink takes it. The input stalls only when the
// queue and the in-flight pixel would fill it. The accumulator RAM (MAX_WIDTH
// words) needs no clearing: the first sample line of each block row
// overwrites its entry. Change enable_fsaa or line_width only while no
// sample is in flight.
module supersample_resolve_4x4 import ssr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ssr_sample_if.sink         i_sample,
    ssr_pixel_if.source        o_pixel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready
);

    localparam int SHIFT_PASS = FRAC_W;
    localparam int SHIFT_AVG  = FRAC_W + 2 * SCALE_LOG2;
    localparam int ONE_PASS   = 1 << SHIFT_PASS;
    localparam int ONE_AVG    = 1 << SHIFT_AVG;

    function automatic logic [PIXEL_W-1:0] to_byte(input logic signed [SUM_W-1:0] s,
                                                   input logic avg);
        logic [SUM_W-1:0]   mag;
        logic [SUM_W-1:0]   lim;
        logic [SUM_W+7:0]   prod;
        logic [PIXEL_W-1:0] res;
        mag  = s;
        lim  = avg ? SUM_W'(ONE_AVG) : SUM_W'(ONE_PASS);
        // times 255 as a shift and subtract
        prod = {mag, 8'h00} - {8'h00, mag};
        if (s[SUM_W-1]) begin
            res = '0;
        end else if (mag > lim) begin
            res = '1;
        end else if (avg) begin
            res = prod[SHIFT_AVG +: PIXEL_W];
        end else begin
            res = prod[SHIFT_PASS +: PIXEL_W];
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    logic             r_enable_fsaa;
    logic [LW_W-1:0]  r_line_width;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_fsaa <= 1'b0;
            r_line_width  <= LW_W'(LW_RESET);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENABLE_FSAA: r_enable_fsaa <= pwdata[0];
                REG_LINE_WIDTH:  r_line_width  <= pwdata[LW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ENABLE_FSAA: prdata = {{(CFG_DW-1){1'b0}}, r_enable_fsaa};
            REG_LINE_WIDTH:  prdata = {{(CFG_DW-LW_W){1'b0}}, r_line_width};
            default:         prdata = '0;
        endcase
    end

    // Clamp the line width into 1..MAX_WIDTH and scale to samples per line
    logic [WID_W-1:0] width;
    logic [LEN_W-1:0] line_len;

    always_comb begin
        if (r_line_width == '0) begin
            width = WID_W'(1);
        end else if (32'(r_line_width) > 32'(MAX_WIDTH)) begin
            width = WID_W'(MAX_WIDTH);
        end else begin
            width = WID_W'(r_line_width);
        end
        line_len = {width, {SCALE_LOG2{1'b0}}};
    end

    // ---------------- accept stage ----------------
    logic                     accept;
    logic                     sof;
    logic signed [SAMPLE_W-1:0] smp [3];

    logic [COL_W-1:0]          r_col, n_col;
    logic [SCALE_LOG2-1:0]     r_sub_row, n_sub_row;
    logic signed [HP_W-1:0]    r_hp [3];
    logic signed [HP_W-1:0]    n_hp [3];
    logic signed [HP_W-1:0]    hp_sum [3];

    logic [COL_W-1:0]          col0;
    logic [LEN_W-1:0]          col_inc;
    logic [SCALE_LOG2-1:0]     sr0;
    logic [OCOL_W-1:0]         ocol0;
    logic                      last_in_block;
    logic                      rd_en;

    assign sof    = i_sample.start_of_frame;
    assign smp[0] = i_sample.sample_red;
    assign smp[1] = i_sample.sample_green;
    assign smp[2] = i_sample.sample_blue;

    always_comb begin
        col0 = sof ? '0 : r_col;
        if ({1'b0, col0} >= line_len) begin
            col0 = '0;
        end
        sr0           = sof ? '0 : r_sub_row;
        ocol0         = col0[COL_W-1:SCALE_LOG2];
        last_in_block = (col0[SCALE_LOG2-1:0] == '1);
        col_inc       = {1'b0, col0} + LEN_W'(1);

        for (int c = 0; c < 3; c++) begin
            hp_sum[c] = (sof ? HP_W'(0) : r_hp[c])
                        + {{(HP_W-SAMPLE_W){smp[c][SAMPLE_W-1]}}, smp[c]};
            n_hp[c]   = last_in_block ? '0 : hp_sum[c];
        end

        if (col_inc >= line_len) begin
            n_col     = '0;
            n_sub_row = sr0 + SCALE_LOG2'(1);
            for (int c = 0; c < 3; c++) begin
                n_hp[c] = '0;
            end
        end else begin
            n_col     = col_inc[COL_W-1:0];
            n_sub_row = sr0;
        end
    end

    // The first sample line of a block row overwrites, so skip its read
    assign rd_en = accept && r_enable_fsaa && last_in_block && (sr0 != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_sub_row <= '0;
            for (int c = 0; c < 3; c++) begin
                r_hp[c] <= '0;
            end
        end else if (accept) begin
            if (r_enable_fsaa) begin
                r_col     <= n_col;
                r_sub_row <= n_sub_row;
                r_hp      <= n_hp;
            end else if (sof) begin
                r_col     <= '0;
                r_sub_row <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_hp[c] <= '0;
                end
            end
        end
    end

    // ---------------- accumulate stage ----------------
    logic                   r_s1_valid;
    logic                   r_s1_emit;
    logic                   r_s1_avg;
    logic                   r_s1_first;
    logic                   r_s1_we;
    logic [OCOL_W-1:0]      r_s1_ocol;
    logic signed [HP_W-1:0] r_s1_val [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_avg   <= r_enable_fsaa;
            r_s1_emit  <= !r_enable_fsaa || (last_in_block && (sr0 == '1));
            r_s1_we    <= r_enable_fsaa && last_in_block;
            r_s1_first <= (sr0 == '0);
            r_s1_ocol  <= ocol0;
            for (int c = 0; c < 3; c++) begin
                r_s1_val[c] <= r_enable_fsaa ? hp_sum[c]
                               : {{(HP_W-SAMPLE_W){smp[c][SAMPLE_W-1]}}, smp[c]};
            end
        end
    end

    logic [ACC_W-1:0]        r_row_acc [MAX_WIDTH];
    logic [ACC_W-1:0]        r_rd_data;
    logic [ACC_W-1:0]        wr_data;
    logic                    wr_en;
    logic signed [SUM_W-1:0] val_ext [3];
    logic signed [SUM_W-1:0] sum [3];

    assign wr_en = r_s1_valid && r_s1_we;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            val_ext[c] = {{(SUM_W-HP_W){r_s1_val[c][HP_W-1]}}, r_s1_val[c]};
            if (r_s1_avg && !r_s1_first) begin
                sum[c] = signed'(r_rd_data[c*SUM_W +: SUM_W]) + val_ext[c];
            end else begin
                sum[c] = val_ext[c];
            end
            wr_data[c*SUM_W +: SUM_W] = sum[c];
        end
    end

    // Read-modify-write: a column's entry is read again at least SCALE samples
    // later, even across a start of frame, so the write-back lands before it
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_row_acc[ocol0];
        end
        if (wr_en) begin
            r_row_acc[r_s1_ocol] <= wr_data;
        end
    end

    // ---------------- output queue ----------------
    t_pixel        s1_pixel;
    t_pixel        q_pixel;
    t_queue_status q_status;
    logic          q_push;
    logic          q_valid;

    assign s1_pixel.red   = to_byte(sum[0], r_s1_avg);
    assign s1_pixel.green = to_byte(sum[1], r_s1_avg);
    assign s1_pixel.blue  = to_byte(sum[2], r_s1_avg);
    assign q_push         = r_s1_valid && r_s1_emit;

    ssr_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (s1_pixel),
        .i_pop    (o_pixel.ready),
        .o_valid  (q_valid),
        .o_data   (q_pixel),
        .o_status (q_status)
    );

    // Leave room for the pixel in flight and the one a new sample may add
    assign i_sample.ready = ({1'b0, q_status.count} + (QCNT_W+1)'(q_push))
                            <= (QCNT_W+1)'(QUEUE_DEPTH - 1);
    assign accept         = i_sample.valid && i_sample.ready;

    assign o_pixel.valid       = q_valid;
    assign o_pixel.pixel_blue  = q_pixel.blue;
    assign o_pixel.pixel_green = q_pixel.green;
    assign o_pixel.pixel_red   = q_pixel.red;
    assign o_pixel.pixel_alpha = ALPHA_OPAQUE;

    // ---------------- assertions ----------------
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (ocol0 != r_s1_ocol))
        else $error("row accumulator read and write-back hit the same column");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("output queue overflow");

    a_sof_restarts_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && sof && r_enable_fsaa) |=> (r_col == COL_W'(1)))
        else $error("start of frame did not restart the sample column");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for supersample_resolve_4x4: random and directed sample streams,
// APB register writes between phases, pixel checks against a behavioral predictor.
// Depends on ssr_pkg, ssr_sample_if, ssr_pixel_if and the block itself.
module tb_top import ssr_pkg::*; ();

    localparam int ITEM_TARGET   = 1700;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ONE_Q         = 1 << FRAC_W;

    typedef struct {
        bit                         sof;
        logic signed [SAMPLE_W-1:0] red;
        logic signed [SAMPLE_W-1:0] green;
        logic signed [SAMPLE_W-1:0] blue;
    } t_color_sample;

    // Tracks the block's counters, sums and registers; queues pixels to come.
    class resolve_scoreboard;
        int          acc_sum[MAX_WIDTH][3];
        bit          acc_written[MAX_WIDTH];
        int          hpart[3];
        int unsigned col;
        int unsigned srow;
        bit          fsaa;
        int unsigned width_reg;
        t_pixel      expected_pixels[$];
        int          errors;

        function new();
            hpart     = '{default: 0};
            col       = 0;
            srow      = 0;
            fsaa      = 1'b0;
            width_reg = LW_RESET;
            errors    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DW-1:0] value);
            case (idx)
                REG_ENABLE_FSAA: fsaa = value[0];
                REG_LINE_WIDTH:  width_reg = value[LW_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned line_pixels();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function logic [PIXEL_W-1:0] to_byte(int sum, int denom);
            if (sum < 0) return '0;
            if (sum > denom) return '1;
            return PIXEL_W'((longint'(sum) * 255) / denom);
        endfunction

        function t_pixel resolve_pixel(int ch[3], int denom);
            t_pixel px;
            px.blue  = to_byte(ch[2], denom);
            px.green = to_byte(ch[1], denom);
            px.red   = to_byte(ch[0], denom);
            return px;
        endfunction

        // True when this sample would close a block against an accumulator
        // entry that no first line has written yet.
        function bit would_read_blank(bit sof);
            int unsigned c;
            int unsigned r;
            if (!fsaa || sof) return 1'b0;
            c = (col >= line_pixels() * SCALE) ? 0 : col;
            r = (srow >= SCALE) ? 0 : srow;
            return (c % SCALE == SCALE - 1) && (r != 0) && !acc_written[c / SCALE];
        endfunction

        function void note_sample(t_color_sample s);
            int          ch[3];
            int unsigned len;
            int unsigned ocol;
            int unsigned sub;
            ch[0] = s.red;
            ch[1] = s.green;
            ch[2] = s.blue;
            if (s.sof) begin
                col   = 0;
                srow  = 0;
                hpart = '{default: 0};
            end
            if (!fsaa) begin
                expected_pixels.push_back(resolve_pixel(ch, ONE_Q));
                return;
            end
            len = line_pixels() * SCALE;
            // wrap a column left past the end by a narrower width
            if (col >= len) col = 0;
            if (srow >= SCALE) srow = 0;
            ocol = col / SCALE;
            sub  = col % SCALE;
            for (int i = 0; i < 3; i++) hpart[i] += ch[i];
            if (sub == SCALE - 1 && ocol < MAX_WIDTH) begin
                for (int i = 0; i < 3; i++) begin
                    if (srow == 0) acc_sum[ocol][i] = hpart[i];
                    else acc_sum[ocol][i] += hpart[i];
                    hpart[i] = 0;
                end
                if (srow == 0) acc_written[ocol] = 1'b1;
                if (srow == SCALE - 1)
                    expected_pixels.push_back(resolve_pixel(acc_sum[ocol],
                                                            SCALE * SCALE * ONE_Q));
            end
            col++;
            if (col >= len) begin
                col   = 0;
                srow  = (srow + 1) % SCALE;
                hpart = '{default: 0};
            end
        endfunction

        function void compare_byte(string name, logic [PIXEL_W-1:0] exp_v,
                                   logic [PIXEL_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_pixel(logic [PIXEL_W-1:0] blue, logic [PIXEL_W-1:0] green,
                                  logic [PIXEL_W-1:0] red, logic [PIXEL_W-1:0] alpha);
            t_pixel exp_px;
            if (expected_pixels.size() == 0) begin
                $display("%0t: pixel with none expected, actual b=%0d g=%0d r=%0d a=%0d",
                         $time, blue, green, red, alpha);
                errors++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            compare_byte("blue", exp_px.blue, blue);
            compare_byte("green", exp_px.green, green);
            compare_byte("red", exp_px.red, red);
            compare_byte("alpha", ALPHA_OPAQUE, alpha);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    ssr_sample_if smp_if ();
    ssr_pixel_if  pix_if ();

    resolve_scoreboard sb;
    int  samples_in  = 0;
    int  cycles      = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    logic calm;

    supersample_resolve_4x4 uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_pixel  (pix_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // both sides run without gaps through this stretch of the stream
    assign calm = (samples_in >= 700) && (samples_in < 1000);

    // Pixel sink: random stalls, plus one long hold-off to back up the block.
    always @(posedge i_clk) begin
        if (!hold_done && samples_in >= HOLD_AT) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            pix_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            pix_if.ready <= 1'b0;
        end else if (calm) begin
            pix_if.ready <= 1'b1;
        end else begin
            pix_if.ready <= ($urandom_range(99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.check_pixel(pix_if.pixel_blue, pix_if.pixel_green,
                           pix_if.pixel_red, pix_if.pixel_alpha);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(input t_color_sample s);
        while (!calm && $urandom_range(99) < 36) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid          <= 1'b1;
        smp_if.start_of_frame <= s.sof;
        smp_if.sample_red     <= s.red;
        smp_if.sample_green   <= s.green;
        smp_if.sample_blue    <= s.blue;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sb.note_sample(s);
        samples_in++;
    endtask

    task automatic send_rgb(input bit sof, input int r, input int g, input int b);
        t_color_sample s;
        s.sof   = sof;
        s.red   = SAMPLE_W'(r);
        s.green = SAMPLE_W'(g);
        s.blue  = SAMPLE_W'(b);
        send_sample(s);
    endtask

    // Wait out every expected pixel, then the words still in the pipe.
    task automatic drain_pixels();
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_channel();
        case ($urandom_range(9))
            0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2, 3:    return SAMPLE_W'($urandom());
            9:       return ($urandom_range(1) != 0) ? SAMPLE_W'(ONE_Q) : '0;
            default: return SAMPLE_W'(int'($urandom_range(ONE_Q + 128)) - 64);
        endcase
    endfunction

    function automatic int unsigned pick_width();
        case ($urandom_range(19))
            0:                         return 0;
            1:                         return $urandom_range(MAX_WIDTH + 1, 4095);
            2:                         return MAX_WIDTH;
            3, 4, 5, 6, 7, 8, 9, 10,
            11, 12:                    return $urandom_range(1, 4);
            default:                   return $urandom_range(5, 12);
        endcase
    endfunction

    task automatic run_phase(input int n, input bit sof_first);
        t_color_sample s;
        for (int k = 0; k < n; k++) begin
            s.sof   = (k == 0 && sof_first) || ($urandom_range(149) == 0);
            s.red   = rand_channel();
            s.green = rand_channel();
            s.blue  = rand_channel();
            // restart the frame rather than close a block on a blank entry
            if (sb.would_read_blank(s.sof)) s.sof = 1'b1;
            send_sample(s);
        end
        smp_if.valid <= 1'b0;
    endtask

    initial begin
        int          forced_width[4];
        bit          forced_fsaa[4];
        int          phase_no;
        int          n;
        bit          fsaa;
        int unsigned lw;

        forced_width = '{0, 0, MAX_WIDTH, 4095};
        forced_fsaa  = '{1'b0, 1'b1, 1'b1, 1'b1};
        sb = new();
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        smp_if.valid          <= 1'b0;
        smp_if.start_of_frame <= 1'b0;
        smp_if.sample_red     <= '0;
        smp_if.sample_green   <= '0;
        smp_if.sample_blue    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass mode out of reset: rounding edges and saturation per channel
        send_rgb(1'b1, 0, ONE_Q, ONE_Q - 1);
        send_rgb(1'b0, 32767, -32768, -1);
        send_rgb(1'b0, ONE_Q + 1, 1, 17);
        send_rgb(1'b0, ONE_Q / 2, -ONE_Q, 3000);
        send_rgb(1'b0, 16'h5555, 16'hAAAA, 1);
        smp_if.valid <= 1'b0;
        drain_pixels();

        // one 4x4 block at width 1: red sums to exactly full scale,
        // green to one below it, blue saturates
        write_reg(REG_ENABLE_FSAA, 1);
        write_reg(REG_LINE_WIDTH, 1);
        for (int k = 0; k < SCALE * SCALE; k++)
            send_rgb(k == 0, ONE_Q, (k == 0) ? ONE_Q - 1 : ONE_Q, 32767);
        smp_if.valid <= 1'b0;

        phase_no = 0;
        while (samples_in < ITEM_TARGET) begin
            drain_pixels();
            if (phase_no < 4) begin
                fsaa = forced_fsaa[phase_no];
                lw   = forced_width[phase_no];
            end else begin
                fsaa = ($urandom_range(2) != 0);
                lw   = pick_width();
            end
            write_reg(REG_ENABLE_FSAA, ($urandom() & ~32'h1) | fsaa);
            write_reg(REG_LINE_WIDTH, ($urandom() << LW_W) | lw);
            if (phase_no == 0) begin
                n = 120;
            end else if (!fsaa) begin
                n = $urandom_range(20, 80);
            end else if (sb.line_pixels() > 64) begin
                n = $urandom_range(8, 40);
            end else begin
                n = SCALE * SCALE * sb.line_pixels() * $urandom_range(1, 2);
                // leave some lines open so the next width lands mid-line
                if ($urandom_range(1) != 0)
                    n += $urandom_range(1, SCALE * sb.line_pixels() - 1 + SCALE);
            end
            run_phase(n, $urandom_range(2) != 0);
            phase_no++;
        end

        drain_pixels();
        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
